// File: rtl/pvram_pkg.sv
package pvram_pkg;

    // video ram geometry
    localparam int VRAM_BYTES = 16384;
    localparam int BANK_DEPTH = VRAM_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int OFF_W      = $clog2(VRAM_BYTES);

    // bus and register widths
    localparam int ADDR_W    = 18;
    localparam int WIDTH_W   = 11;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // register indexes (paddr bit 2)
    localparam logic REG_VRAM_BASE     = 1'b0;
    localparam logic REG_DISPLAY_WIDTH = 1'b1;

    localparam logic [ADDR_W-1:0]  VRAM_BASE_RESET     = '0;
    localparam logic [WIDTH_W-1:0] DISPLAY_WIDTH_RESET = 11'd256;

    // transfer kinds
    localparam logic [2:0] KIND_RD_BYTE = 3'd0;
    localparam logic [2:0] KIND_RD_WORD = 3'd1;
    localparam logic [2:0] KIND_WR_BYTE = 3'd2;
    localparam logic [2:0] KIND_WR_WORD = 3'd3;
    localparam logic [2:0] KIND_PIXEL   = 3'd4;

    // grey expansion
    localparam logic [7:0] GREY_STEP  = 8'd85;
    localparam logic [1:0] LEVEL_MASK = 2'h3;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] bus_address;
        logic [15:0]       write_data;
        logic [9:0]        pixel_x;
        logic [9:0]        pixel_y;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [23:0] pixel_rgb;
        logic        address_error;
    } rsp_t;

    // one access to a byte bank
    typedef struct packed {
        logic               en;
        logic               we;
        logic [BANK_AW-1:0] addr;
        logic [7:0]         wdata;
    } bank_req_t;

endpackage

// File: rtl/pvram_bank.sv
module pvram_bank
    import pvram_pkg::*;
(
    input  logic      clk,
    input  bank_req_t acc,
    output logic [7:0] rdata
);

    logic [7:0] mem [BANK_DEPTH];
    logic [7:0] rdata_reg;

    // read-first, registered read data
    always_ff @(posedge clk)
    begin
        if (acc.en)
        begin
            if (acc.we)
            begin
                mem[acc.addr] <= acc.wdata;
            end
            rdata_reg <= mem[acc.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pvram_ctrl.sv
module pvram_ctrl
    import pvram_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ADDR_W-1:0]  vram_base,
    input  logic [WIDTH_W-1:0] display_width,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    output bank_req_t          even_acc,
    output bank_req_t          odd_acc,
    input  logic [7:0]         even_rdata,
    input  logic [7:0]         odd_rdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_MEM  = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               clear_busy_reg, clear_busy_next;
    logic [BANK_AW-1:0] clear_addr_reg, clear_addr_next;
    logic               rsp_valid_reg, rsp_valid_next;

    req_t               item_reg;
    logic [20:0]        product_reg;
    logic               win1_reg, win2_reg;
    logic [OFF_W-1:0]   off_reg;
    logic               ok_reg, err_reg, off0_reg;
    logic [1:0]         pix_lo_reg;
    rsp_t               rsp_reg;

    // window test
    logic [ADDR_W:0]    diff;
    logic               below;
    logic [ADDR_W-1:0]  delta;

    // pixel index and access issue
    logic [21:0]        pix;
    logic [19:0]        byte_at;
    logic               pix_ok;
    logic               ok;
    logic               err;
    logic [OFF_W-1:0]   off;
    logic               is_write, is_word;

    // response forming
    logic [7:0]         lo_byte, hi_byte;
    logic [7:0]         shifted;
    logic [1:0]         level;
    logic [7:0]         grey;
    rsp_t               result;
    logic               load;

    assign req_ready = (state_reg == ST_IDLE) && !clear_busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign diff  = {1'b0, item_reg.bus_address} - {1'b0, vram_base};
    assign below = diff[ADDR_W];
    assign delta = diff[ADDR_W-1:0];

    assign pix     = 22'(item_reg.pixel_x) + 22'(product_reg);
    assign byte_at = pix[21:2];
    assign pix_ok  = 21'(byte_at) < 21'(VRAM_BYTES);

    always_comb
    begin
        ok       = 1'b0;
        err      = 1'b0;
        is_write = 1'b0;
        is_word  = 1'b0;
        off      = off_reg;
        case (item_reg.kind) inside
            KIND_RD_BYTE, KIND_WR_BYTE:
            begin
                ok       = win1_reg;
                err      = !win1_reg;
                is_write = item_reg.kind == KIND_WR_BYTE;
            end
            KIND_RD_WORD, KIND_WR_WORD:
            begin
                ok       = win2_reg;
                err      = !win2_reg;
                is_word  = 1'b1;
                is_write = item_reg.kind == KIND_WR_WORD;
            end
            KIND_PIXEL:
            begin
                ok  = pix_ok;
                err = !pix_ok;
                off = byte_at[OFF_W-1:0];
            end
            default:
            begin
                ok  = 1'b0;
                err = 1'b0;
            end
        endcase
    end

    // bank ports: clearing sweep, or the access of the current item
    always_comb
    begin
        even_acc = '0;
        odd_acc  = '0;
        if (clear_busy_reg)
        begin
            even_acc.en   = 1'b1;
            even_acc.we   = 1'b1;
            even_acc.addr = clear_addr_reg;
            odd_acc.en    = 1'b1;
            odd_acc.we    = 1'b1;
            odd_acc.addr  = clear_addr_reg;
        end
        else if (state_reg == ST_MEM && ok)
        begin
            // an odd offset puts the even byte one row up
            even_acc.en    = 1'b1;
            even_acc.addr  = BANK_AW'(off[OFF_W-1:1] + BANK_AW'(off[0]));
            even_acc.we    = is_write && (is_word || !off[0]);
            even_acc.wdata = off[0] ? item_reg.write_data[15:8]
                                    : item_reg.write_data[7:0];
            odd_acc.en     = 1'b1;
            odd_acc.addr   = off[OFF_W-1:1];
            odd_acc.we     = is_write && (is_word || off[0]);
            odd_acc.wdata  = off[0] ? item_reg.write_data[7:0]
                                    : item_reg.write_data[15:8];
        end
    end

    assign lo_byte = off0_reg ? odd_rdata : even_rdata;
    assign hi_byte = off0_reg ? even_rdata : odd_rdata;
    assign shifted = lo_byte >> {pix_lo_reg, 1'b0};
    assign level   = shifted[1:0] & LEVEL_MASK;
    assign grey    = 8'(8'(level) * GREY_STEP);

    always_comb
    begin
        result               = '0;
        result.address_error = err_reg;
        if (ok_reg)
        begin
            case (item_reg.kind)
                KIND_RD_BYTE: result.read_data = {8'h00, lo_byte};
                KIND_RD_WORD: result.read_data = {hi_byte, lo_byte};
                KIND_PIXEL:   result.pixel_rgb = {grey, grey, grey};
                default:      result.read_data = '0;
            endcase
        end
    end

    assign load = (state_reg == ST_RESP) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_valid && req_ready) state_next = ST_CALC;
            ST_CALC: state_next = ST_MEM;
            ST_MEM:  state_next = ST_RESP;
            ST_RESP: if (load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == BANK_AW'(BANK_DEPTH - 1))
            begin
                clear_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        if (state_reg == ST_CALC)
        begin
            product_reg <= 21'(item_reg.pixel_y) * 21'(display_width);
            win1_reg    <= !below && ({1'b0, delta} < (ADDR_W + 1)'(VRAM_BYTES));
            win2_reg    <= !below && ({1'b0, delta} < (ADDR_W + 1)'(VRAM_BYTES - 1));
            off_reg     <= delta[OFF_W-1:0];
        end
        if (state_reg == ST_MEM)
        begin
            ok_reg     <= ok;
            err_reg    <= err;
            off0_reg   <= off[0];
            pix_lo_reg <= pix[1:0];
        end
        if (load)
        begin
            rsp_reg <= result;
        end
    end

endmodule

// File: rtl/packed_2bpp_video_ram_top.sv
// Byte-wide 2 bpp grey video ram on a bus. Each request transfer is a byte
// or little-endian word read or write at an 18-bit bus address, or a pixel
// fetch by x,y; each one gives exactly one response transfer carrying read
// data, a 24-bit grey RGB pixel and an address error flag. A request is
// taken only once the single-item sequencer has passed the previous one
// through its states (accept, window test and pixel multiply, ram access,
// response) around the registered-read ram; a new request is taken while
// the previous response still waits in the output register. The ram is
// split into even and odd byte banks so an unaligned word touches both in
// one access. After reset a clearing pass zeroes the ram, during which no
// request is taken; register writes are taken at any time. Registers:
// vram_base at byte address 0, display_width at byte address 4.
module packed_2bpp_video_ram_top
    import pvram_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [ADDR_W-1:0]  vram_base_reg, vram_base_next;
    logic [WIDTH_W-1:0] display_width_reg, display_width_next;
    logic               reg_index;
    logic               reg_write;

    bank_req_t          even_acc, odd_acc;
    logic [7:0]         even_rdata, odd_rdata;

    // register port: zero wait states
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign reg_write = psel && penable && pwrite && pready;

    // register write decode
    always_comb
    begin
        vram_base_next     = vram_base_reg;
        display_width_next = display_width_reg;
        if (reg_write)
        begin
            unique case (reg_index)
                REG_VRAM_BASE:     vram_base_next     = pwdata[ADDR_W-1:0];
                REG_DISPLAY_WIDTH: display_width_next = pwdata[WIDTH_W-1:0];
                default:           vram_base_next     = vram_base_reg;
            endcase
        end
    end

    // register read back, zero extended
    always_comb
    begin
        unique case (reg_index)
            REG_VRAM_BASE:     prdata = PDATA_W'(vram_base_reg);
            REG_DISPLAY_WIDTH: prdata = PDATA_W'(display_width_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vram_base_reg     <= VRAM_BASE_RESET;
            display_width_reg <= DISPLAY_WIDTH_RESET;
        end
        else
        begin
            vram_base_reg     <= vram_base_next;
            display_width_reg <= display_width_next;
        end
    end

    // sequencer: window test, pixel index, bank access, response register
    pvram_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .vram_base     (vram_base_reg),
        .display_width (display_width_reg),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .even_acc      (even_acc),
        .odd_acc       (odd_acc),
        .even_rdata    (even_rdata),
        .odd_rdata     (odd_rdata)
    );

    // even byte offsets
    pvram_bank u_even_bank (
        .clk   (clk),
        .acc   (even_acc),
        .rdata (even_rdata)
    );

    // odd byte offsets
    pvram_bank u_odd_bank (
        .clk   (clk),
        .acc   (odd_acc),
        .rdata (odd_rdata)
    );

endmodule
